FILE: rtl/chcs_pkg.sv
// Package for the cubic Hermite curve sampler: shared types and constants.
package chcs_pkg;

  // Default coordinate width (Q8.8)
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Sample count register
  localparam int unsigned NW            = 7;
  localparam logic [NW-1:0] PPS_RESET   = 7'd16;
  localparam logic [NW-1:0] MAX_SAMPLES = 7'd64;
  localparam int unsigned JW            = 6;

  // Curve parameter t, Q0.16
  localparam int unsigned TW = 16;

  // 65536/n by restoring division, one quotient bit per cycle
  localparam int unsigned QW            = 17;
  localparam int unsigned RW            = 6;
  localparam logic [4:0]  DIV_LAST_STEP = 5'd16;

  // Hermite basis weights, signed Q.16
  localparam int unsigned HW                = 19;
  localparam logic signed [HW-1:0] ONE_Q16  = 19'sh10000;

  // Rounding constant placed below the accumulator's integer part
  localparam logic [TW-1:0] HALF_Q16 = 16'h8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CU,
    ST_HB,
    ST_ACC,
    ST_OUT
  } state_e;

  // Product terms of one coordinate, in issue order
  typedef enum logic [1:0] {
    TERM_DP,
    TERM_M0,
    TERM_M1
  } term_e;

endpackage

FILE: rtl/chcs_point_if.sv
// Input channel: one control point with its tangent per item.
interface chcs_point_if #(
  parameter int unsigned COORD_WIDTH = chcs_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          first_point;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] slope_x;
  logic signed [COORD_WIDTH-1:0] slope_y;
  logic signed [COORD_WIDTH-1:0] slope_z;

  modport source (
    output valid, first_point, point_x, point_y, point_z, slope_x, slope_y, slope_z,
    input  ready
  );

  modport sink (
    input  valid, first_point, point_x, point_y, point_z, slope_x, slope_y, slope_z,
    output ready
  );
endinterface

FILE: rtl/chcs_curve_if.sv
// Output channel: one curve sample per item.
interface chcs_curve_if #(
  parameter int unsigned COORD_WIDTH = chcs_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] curve_x;
  logic signed [COORD_WIDTH-1:0] curve_y;
  logic signed [COORD_WIDTH-1:0] curve_z;
  logic                          segment_end;

  modport source (
    output valid, curve_x, curve_y, curve_z, segment_end,
    input  ready
  );

  modport sink (
    input  valid, curve_x, curve_y, curve_z, segment_end,
    output ready
  );
endinterface

FILE: rtl/chcs_mul.sv
// Shared signed multiplier with a registered product.
module chcs_mul #(
  parameter int unsigned AW = chcs_pkg::HW,
  parameter int unsigned BW = chcs_pkg::TW + 1
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  logic signed [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/cubic_hermite_curve_sampler.sv
// Top level of the cubic Hermite curve sampler.
//
// Usage notes
// - point_i takes one control point and its tangent per item (valid/ready).
//   An item with first_point set, or any item while no point is stored, is
//   only stored and gives no output. Every later item closes a segment from
//   the stored point/tangent to the new one.
// - curve_o gives n samples per segment, n = points_per_segment (0 acts as 1,
//   above 64 acts as 64); segment_end marks the last of them.
// - cfg_we_i/cfg_data_i write points_per_segment; write only while idle.
// - Sequencing: one shared multiplier does all the multiplications. A
//   segment runs the division (65536/n), then per sample t^2, t^3, the
//   basis weights, nine products for three coordinates and their drain,
//   and the output load; a stored-only item is taken in idle and leaves
//   the sequencer there. point_i.ready is high only between items.
// - The output register holds a finished sample until it is taken; a stall
//   on curve_o holds the sequencer in its output step, nothing is dropped.
// - Reset clears the stored-point flag, the sequencer and the output valid,
//   and sets points_per_segment to 16.
module cubic_hermite_curve_sampler #(
  parameter int unsigned COORD_WIDTH = chcs_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [chcs_pkg::NW-1:0]    cfg_data_i,
  chcs_point_if.sink                 point_i,
  chcs_curve_if.source               curve_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned HW   = chcs_pkg::HW;
  localparam int unsigned TW   = chcs_pkg::TW;
  // multiplier B side: coordinate difference, tangent or unsigned t
  localparam int unsigned MB   = (CW + 1 > TW + 1) ? CW + 1 : TW + 1;
  localparam int unsigned PW   = HW + MB;
  localparam int unsigned ACCW = PW + 2;
  localparam int unsigned AHW  = ACCW - TW;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  chcs_pkg::state_e state_q, state_d;
  logic                     have_prev_q;
  logic [chcs_pkg::NW-1:0]  pps_q;
  logic [chcs_pkg::NW-1:0]  n_q;

  logic [4:0]               divc_q;
  logic [chcs_pkg::QW-1:0]  quo_q;     // floor(65536/n)
  logic [chcs_pkg::RW-1:0]  rem_q;     // 65536 mod n
  logic [chcs_pkg::RW-1:0]  frac_q;    // running remainder of j*65536/n
  logic [TW-1:0]            t_q;
  logic [chcs_pkg::JW-1:0]  j_q;
  logic [TW-1:0]            t2_q;
  logic signed [HW-1:0]     h0_q, h2_q, h3_q;

  chcs_pkg::term_e          k_q;       // term being issued
  logic [1:0]               c_q;       // coordinate being issued
  logic                     iss_done_q;
  logic                     pv_q;      // product register holds a term
  chcs_pkg::term_e          pk_q;

  logic signed [ACCW-1:0]   acc_q;
  logic signed [CW-1:0]     res_q [3];

  // point/tangent sets; rotated one place per coordinate, index 0 is current
  logic signed [CW-1:0]     p0_q [3];
  logic signed [CW-1:0]     m0_q [3];
  logic signed [CW-1:0]     p1_q [3];
  logic signed [CW-1:0]     m1_q [3];

  logic                     ovalid_q;
  logic signed [CW-1:0]     ox_q, oy_q, oz_q;
  logic                     oend_q;

  // ---------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------
  logic                     mul_en;
  logic signed [HW-1:0]     mul_a;
  logic signed [MB-1:0]     mul_b;
  logic signed [PW-1:0]     prod;

  chcs_mul #(
    .AW (HW),
    .BW (MB)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [CW-1:0] sat_round(input logic signed [ACCW-1:0] a);
    logic [ACCW-CW-TW:0] hi;
    logic signed [CW-1:0] r;
    hi = a[ACCW-1:CW+TW-1];
    if ((&hi) || !(|hi)) begin
      r = a[CW+TW-1:TW];
    end else if (a[ACCW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

  logic [chcs_pkg::NW-1:0]  n_eff;
  logic                     in_acc;
  logic                     in_pair;
  logic                     out_free;
  logic                     last_sample;

  logic [chcs_pkg::RW:0]    div_sh;
  logic                     div_ge;
  logic [chcs_pkg::RW:0]    frac_sum;
  logic                     frac_ge;
  logic [chcs_pkg::QW-1:0]  t_next;

  logic [TW-1:0]            t3_w;
  logic signed [HW-1:0]     t_x, t2_x, t3_x;
  logic signed [CW:0]       dp_w;
  logic signed [ACCW-1:0]   acc_base;
  logic signed [ACCW-1:0]   acc_sum;

  // n is taken from the register with its limits applied
  always_comb begin
    if (pps_q == '0) begin
      n_eff = chcs_pkg::NW'(1);
    end else if (pps_q > chcs_pkg::MAX_SAMPLES) begin
      n_eff = chcs_pkg::MAX_SAMPLES;
    end else begin
      n_eff = pps_q;
    end
  end

  assign in_acc      = point_i.valid && point_i.ready;
  assign in_pair     = in_acc && !point_i.first_point && have_prev_q;
  assign out_free    = !ovalid_q || curve_o.ready;
  assign last_sample = ({1'b0, j_q} == (n_q - chcs_pkg::NW'(1)));

  // 65536 = 1 followed by sixteen zeros: MSB first
  assign div_sh = {rem_q, (divc_q == '0)};
  assign div_ge = (div_sh >= n_q);

  assign frac_sum = {1'b0, frac_q} + {1'b0, rem_q};
  assign frac_ge  = (frac_sum >= n_q);
  assign t_next   = {1'b0, t_q} + quo_q + chcs_pkg::QW'(frac_ge);

  // basis weights from t, t^2 and (in ST_HB) t^3 off the product register
  assign t3_w = prod[2*TW-1:TW];
  assign t_x  = {{(HW-TW){1'b0}}, t_q};
  assign t2_x = {{(HW-TW){1'b0}}, t2_q};
  assign t3_x = {{(HW-TW){1'b0}}, t3_w};

  assign dp_w = (CW+1)'(p0_q[0]) - (CW+1)'(p1_q[0]);

  // p1<<16 plus the rounding half, then the three products on top
  assign acc_base = $signed({AHW'(p1_q[0]), chcs_pkg::HALF_Q16});
  assign acc_sum  = ((pk_q == chcs_pkg::TERM_DP) ? acc_base : acc_q) + ACCW'(prod);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      chcs_pkg::ST_IDLE: begin
        if (in_pair) begin
          state_d = chcs_pkg::ST_DIV;
        end
      end
      chcs_pkg::ST_DIV: begin
        if (divc_q == chcs_pkg::DIV_LAST_STEP) begin
          state_d = chcs_pkg::ST_SQ;
        end
      end
      chcs_pkg::ST_SQ:  state_d = chcs_pkg::ST_CU;
      chcs_pkg::ST_CU:  state_d = chcs_pkg::ST_HB;
      chcs_pkg::ST_HB:  state_d = chcs_pkg::ST_ACC;
      chcs_pkg::ST_ACC: begin
        if (iss_done_q && !pv_q) begin
          state_d = chcs_pkg::ST_OUT;
        end
      end
      chcs_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = last_sample ? chcs_pkg::ST_IDLE : chcs_pkg::ST_SQ;
        end
      end
      default: state_d = chcs_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (handshake and multiplier operands)
  // ---------------------------------------------------------------------
  always_comb begin
    point_i.ready = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      chcs_pkg::ST_IDLE: point_i.ready = 1'b1;
      chcs_pkg::ST_SQ: begin
        mul_en = 1'b1;
        mul_a  = t_x;
        mul_b  = {{(MB-TW){1'b0}}, t_q};
      end
      chcs_pkg::ST_CU: begin
        mul_en = 1'b1;
        mul_a  = {{(HW-TW){1'b0}}, prod[2*TW-1:TW]};
        mul_b  = {{(MB-TW){1'b0}}, t_q};
      end
      chcs_pkg::ST_ACC: begin
        mul_en = !iss_done_q;
        case (k_q)
          chcs_pkg::TERM_DP: begin
            mul_a = h0_q;
            mul_b = MB'(dp_w);
          end
          chcs_pkg::TERM_M0: begin
            mul_a = h2_q;
            mul_b = MB'(m0_q[0]);
          end
          chcs_pkg::TERM_M1: begin
            mul_a = h3_q;
            mul_b = MB'(m1_q[0]);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        point_i.ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chcs_pkg::ST_IDLE;
      have_prev_q <= 1'b0;
      pps_q       <= chcs_pkg::PPS_RESET;
      ovalid_q    <= 1'b0;
      pv_q        <= 1'b0;
      iss_done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pps_q <= cfg_data_i;
      end
      if (in_acc) begin
        have_prev_q <= 1'b1;
      end
      if (state_q == chcs_pkg::ST_HB) begin
        iss_done_q <= 1'b0;
        pv_q       <= 1'b0;
      end else if (state_q == chcs_pkg::ST_ACC) begin
        pv_q <= !iss_done_q;
        if (!iss_done_q && k_q == chcs_pkg::TERM_M1 && c_q == 2'd2) begin
          iss_done_q <= 1'b1;
        end
      end
      if (state_q == chcs_pkg::ST_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (curve_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_pair) begin
        p1_q[0] <= point_i.point_x;
        p1_q[1] <= point_i.point_y;
        p1_q[2] <= point_i.point_z;
        m1_q[0] <= point_i.slope_x;
        m1_q[1] <= point_i.slope_y;
        m1_q[2] <= point_i.slope_z;
        n_q     <= n_eff;
        divc_q  <= '0;
        quo_q   <= '0;
        rem_q   <= '0;
      end else begin
        p0_q[0] <= point_i.point_x;
        p0_q[1] <= point_i.point_y;
        p0_q[2] <= point_i.point_z;
        m0_q[0] <= point_i.slope_x;
        m0_q[1] <= point_i.slope_y;
        m0_q[2] <= point_i.slope_z;
      end
    end

    case (state_q)
      chcs_pkg::ST_DIV: begin
        divc_q <= divc_q + 5'd1;
        quo_q  <= {quo_q[chcs_pkg::QW-2:0], div_ge};
        rem_q  <= div_ge ? chcs_pkg::RW'(div_sh - n_q) : chcs_pkg::RW'(div_sh);
        t_q    <= '0;
        frac_q <= '0;
        j_q    <= '0;
      end
      chcs_pkg::ST_CU: begin
        t2_q <= prod[2*TW-1:TW];
      end
      chcs_pkg::ST_HB: begin
        h0_q <= (t3_x <<< 1) - (t2_x + (t2_x <<< 1)) + chcs_pkg::ONE_Q16;
        h2_q <= t3_x - (t2_x <<< 1) + t_x;
        h3_q <= t3_x - t2_x;
        k_q  <= chcs_pkg::TERM_DP;
        c_q  <= 2'd0;
      end
      chcs_pkg::ST_ACC: begin
        if (!iss_done_q) begin
          pk_q <= k_q;
          case (k_q)
            chcs_pkg::TERM_DP: k_q <= chcs_pkg::TERM_M0;
            chcs_pkg::TERM_M0: k_q <= chcs_pkg::TERM_M1;
            default: begin
              k_q <= chcs_pkg::TERM_DP;
              c_q <= c_q + 2'd1;
              // next coordinate moves to index 0
              for (int i = 0; i < 3; i++) begin
                p0_q[i] <= p0_q[(i + 1) % 3];
                p1_q[i] <= p1_q[(i + 1) % 3];
                m0_q[i] <= m0_q[(i + 1) % 3];
                m1_q[i] <= m1_q[(i + 1) % 3];
              end
            end
          endcase
        end
        if (pv_q) begin
          acc_q <= acc_sum;
          if (pk_q == chcs_pkg::TERM_M1) begin
            res_q[2] <= sat_round(acc_sum);
            res_q[1] <= res_q[2];
            res_q[0] <= res_q[1];
          end
        end
      end
      chcs_pkg::ST_OUT: begin
        if (out_free) begin
          ox_q   <= res_q[0];
          oy_q   <= res_q[1];
          oz_q   <= res_q[2];
          oend_q <= last_sample;
          if (last_sample) begin
            // new point becomes the stored one
            p0_q <= p1_q;
            m0_q <= m1_q;
          end else begin
            j_q    <= j_q + chcs_pkg::JW'(1);
            t_q    <= t_next[TW-1:0];
            frac_q <= frac_ge ? chcs_pkg::RW'(frac_sum - n_q) : chcs_pkg::RW'(frac_sum);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign curve_o.valid       = ovalid_q;
  assign curve_o.curve_x     = ox_q;
  assign curve_o.curve_y     = oy_q;
  assign curve_o.curve_z     = oz_q;
  assign curve_o.segment_end = oend_q;

endmodule

FILE: rtl/chcs_checker.sv
// Port-level checks for the curve sampler, bound to the top level.
module chcs_checker #(
  parameter int unsigned COORD_WIDTH = chcs_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pt_valid_i,
  input logic                   pt_ready_i,
  input logic                   pt_first_i,
  input logic                   cv_valid_i,
  input logic                   cv_ready_i,
  input logic [COORD_WIDTH-1:0] cv_x_i,
  input logic                   cv_end_i
);

  // a stalled sample stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_valid_i && !cv_ready_i |=> cv_valid_i)
    else $error("curve item dropped under stall");

  // and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_valid_i && !cv_ready_i |=> $stable(cv_x_i) && $stable(cv_end_i))
    else $error("curve item changed under stall");

  // a curve start only stores, so the block stays open for the next point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && pt_ready_i && pt_first_i |=> pt_ready_i)
    else $error("first point did not return to idle");

  // no sample can appear the cycle after a point is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_valid_i && pt_ready_i |=> !$rose(cv_valid_i))
    else $error("sample appeared straight after an input item");

endmodule

bind cubic_hermite_curve_sampler chcs_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_chcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .pt_valid_i (point_i.valid),
  .pt_ready_i (point_i.ready),
  .pt_first_i (point_i.first_point),
  .cv_valid_i (curve_o.valid),
  .cv_ready_i (curve_o.ready),
  .cv_x_i     (curve_o.curve_x),
  .cv_end_i   (curve_o.segment_end)
);

FILE: dv/tb_cubic_hermite_curve_sampler.sv
// Testbench for the cubic Hermite curve sampler: directed rows, then random curves, self-checked.
module tb_cubic_hermite_curve_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = chcs_pkg::COORD_WIDTH_DEF;
  localparam logic signed [CW-1:0] SAT_HI = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_LO = {1'b1, {(CW-1){1'b0}}};
  // Quiet cycles after the last sample before the register may be touched;
  // the sequencer is already back in idle when it offers the last sample.
  localparam int unsigned SETTLE_CYCLES = 40;

  // One control point with its tangent, as it goes onto the input channel
  typedef struct packed {
    logic                 first;
    logic signed [CW-1:0] px, py, pz;
    logic signed [CW-1:0] sx, sy, sz;
  } point_item_t;

  // One curve sample as it leaves the output channel
  typedef struct packed {
    logic signed [CW-1:0] cx, cy, cz;
    logic                 seg_end;
  } curve_sample_t;

  typedef enum logic {
    ROW_CFG,
    ROW_POINT
  } row_kind_e;

  // Stimulus row: a register write or a point, optionally with its sample typed in
  typedef struct {
    row_kind_e               kind;
    logic [chcs_pkg::NW-1:0] setting;
    point_item_t             item;
    bit                      typed;
    logic signed [CW-1:0]    want_x, want_y, want_z;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [chcs_pkg::NW-1:0] cfg_data_i;

  chcs_point_if #(.COORD_WIDTH(CW)) point_bus ();
  chcs_curve_if #(.COORD_WIDTH(CW)) curve_bus ();

  cubic_hermite_curve_sampler #(.COORD_WIDTH(CW)) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (point_bus),
    .curve_o   (curve_bus)
  );

  // Predictor state: our own copy of the register and the stored point
  logic [chcs_pkg::NW-1:0] samples_setting;
  bit                      have_stored;
  logic signed [CW-1:0]    stored_point [3];
  logic signed [CW-1:0]    stored_slope [3];

  curve_sample_t expected_samples [$];
  stim_row_t     stim_rows [$];

  int unsigned mismatches;
  int unsigned points_sent;
  int unsigned samples_checked;
  int unsigned segments_closed;
  int unsigned rail_hits;
  int unsigned settings_used;
  bit          calm;  // no idling on either side while set

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop, well above the slowest legal run
  initial begin
    #40ms;
    $display("tb_cubic_hermite_curve_sampler: done, errors");
    $finish;
  end

  // Mostly no gap, sometimes a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Random coordinate: rails, small values around zero, or anything at all
  function automatic logic signed [CW-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 2) return SAT_HI;
    if (r < 4) return SAT_LO;
    if (r < 8) return CW'($signed($urandom_range(0, 1023)) - 512);
    return CW'($urandom);
  endfunction

  function automatic stim_row_t cfg_row(logic [chcs_pkg::NW-1:0] v);
    stim_row_t r;
    r = '{kind: ROW_CFG, setting: v, item: '0, typed: 1'b0,
          want_x: '0, want_y: '0, want_z: '0};
    return r;
  endfunction

  function automatic stim_row_t pt_row(logic f,
                                       logic signed [CW-1:0] px, py, pz,
                                       logic signed [CW-1:0] sx, sy, sz);
    stim_row_t r;
    r = cfg_row('0);
    r.kind = ROW_POINT;
    r.item = '{first: f, px: px, py: py, pz: pz, sx: sx, sy: sy, sz: sz};
    return r;
  endfunction

  // Single-sample segment whose value is known without arithmetic
  function automatic stim_row_t typed_row(stim_row_t r,
                                          logic signed [CW-1:0] wx, wy, wz);
    r.typed  = 1'b1;
    r.want_x = wx;
    r.want_y = wy;
    r.want_z = wz;
    return r;
  endfunction

  // Appends one row to the stimulus table
  function automatic void add_row(stim_row_t r);
    stim_rows = {stim_rows, r};
  endfunction

  // Hermite predictor: queues the samples of the segment this point closes
  // (if any), then makes the point and tangent the stored ones.
  function automatic void blend_segment(point_item_t it);
    logic signed [CW-1:0] p1 [3];
    logic signed [CW-1:0] m1 [3];
    logic signed [CW-1:0] coord [3];
    int unsigned          n_eff;
    longint               t, t2, t3, h0, h1, h2, h3, acc, r;
    curve_sample_t        s;
    p1 = '{it.px, it.py, it.pz};
    m1 = '{it.sx, it.sy, it.sz};
    if (!it.first && have_stored) begin
      n_eff = samples_setting;
      if (n_eff == 0) n_eff = 1;
      if (n_eff > chcs_pkg::MAX_SAMPLES) n_eff = chcs_pkg::MAX_SAMPLES;
      for (int unsigned j = 0; j < n_eff; j++) begin
        t  = (longint'(j) <<< 16) / longint'(n_eff);
        t2 = (t * t) / 65536;
        t3 = (t2 * t) / 65536;
        h0 = 2 * t3 - 3 * t2 + 65536;
        h1 = 65536 - h0;
        h2 = t3 - 2 * t2 + t;
        h3 = t3 - t2;
        for (int i = 0; i < 3; i++) begin
          acc = h0 * longint'(stored_point[i]) + h1 * longint'(p1[i])
              + h2 * longint'(stored_slope[i]) + h3 * longint'(m1[i]);
          r = (acc + 32768) >>> 16;  // round half up, also for negatives
          if (r > longint'(SAT_HI)) r = longint'(SAT_HI);
          if (r < longint'(SAT_LO)) r = longint'(SAT_LO);
          coord[i] = CW'(r);
        end
        s = '{cx: coord[0], cy: coord[1], cz: coord[2], seg_end: (j + 1 == n_eff)};
        expected_samples = {expected_samples, s};
      end
    end
    stored_point = p1;
    stored_slope = m1;
    have_stored  = 1'b1;
  endfunction

  // Wait for every expected sample, then let the sequencer fall back to idle
  task automatic settle();
    point_bus.valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_samples_setting(logic [chcs_pkg::NW-1:0] v);
    settle();
    cfg_data_i = v;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i        = 1'b0;
    samples_setting = v;
    settings_used++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items keep it up.
  task automatic send_point(stim_row_t row);
    int unsigned   gap;
    int unsigned   base;
    curve_sample_t s;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      point_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    point_bus.first_point = row.item.first;
    point_bus.point_x     = row.item.px;
    point_bus.point_y     = row.item.py;
    point_bus.point_z     = row.item.pz;
    point_bus.slope_x     = row.item.sx;
    point_bus.slope_y     = row.item.sy;
    point_bus.slope_z     = row.item.sz;
    point_bus.valid       = 1'b1;
    do @(posedge clk_i); while (!point_bus.ready);
    base = expected_samples.size();
    blend_segment(row.item);
    if (row.typed) begin
      // typed value replaces the predicted one
      while (expected_samples.size() > base) void'(expected_samples.pop_back());
      s = '{cx: row.want_x, cy: row.want_y, cz: row.want_z, seg_end: 1'b1};
      expected_samples = {expected_samples, s};
    end
    points_sent++;
    @(negedge clk_i);
  endtask

  // Receiver: random stalls on the output channel
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    curve_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        curve_bus.ready = 1'b0;
        stall_left--;
      end else begin
        curve_bus.ready = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Scoreboard: every sample taken is compared with the oldest expectation
  always @(posedge clk_i) begin
    curve_sample_t want;
    if (rst_ni && curve_bus.valid && curve_bus.ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample x=%0d y=%0d z=%0d end=%0b", curve_bus.curve_x,
               curve_bus.curve_y, curve_bus.curve_z, curve_bus.segment_end);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (curve_bus.curve_x !== want.cx) begin
          $error("curve_x: expected %0d, got %0d", want.cx, curve_bus.curve_x);
          mismatches++;
        end
        if (curve_bus.curve_y !== want.cy) begin
          $error("curve_y: expected %0d, got %0d", want.cy, curve_bus.curve_y);
          mismatches++;
        end
        if (curve_bus.curve_z !== want.cz) begin
          $error("curve_z: expected %0d, got %0d", want.cz, curve_bus.curve_z);
          mismatches++;
        end
        if (curve_bus.segment_end !== want.seg_end) begin
          $error("segment_end: expected %0b, got %0b", want.seg_end,
                 curve_bus.segment_end);
          mismatches++;
        end
        if (want.seg_end) segments_closed++;
        if (want.cx == SAT_HI || want.cx == SAT_LO || want.cy == SAT_HI ||
            want.cy == SAT_LO || want.cz == SAT_HI || want.cz == SAT_LO)
          rail_hits++;
      end
    end
  end

  initial begin
    logic [chcs_pkg::NW-1:0] phase_settings [10];
    int unsigned             n_eff;
    int unsigned             phase_items;
    stim_row_t               row;

    // Everything driven to a known value from time zero
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_data_i            = '0;
    point_bus.valid       = 1'b0;
    point_bus.first_point = 1'b0;
    point_bus.point_x     = '0;
    point_bus.point_y     = '0;
    point_bus.point_z     = '0;
    point_bus.slope_x     = '0;
    point_bus.slope_y     = '0;
    point_bus.slope_z     = '0;
    calm                  = 1'b0;
    mismatches            = 0;
    points_sent           = 0;
    samples_checked       = 0;
    segments_closed       = 0;
    rail_hits             = 0;
    settings_used         = 1;
    samples_setting       = chcs_pkg::PPS_RESET;
    have_stored           = 1'b0;
    stored_point          = '{default: '0};
    stored_slope          = '{default: '0};

    // Directed rows. Typed rows run with one sample per segment, where the
    // only sample (t = 0) is just the stored point.
    // nothing stored yet: a plain point is only stored
    add_row(pt_row(1'b0, 100, -200, 300, 50, -50, 0));
    // ordinary segment at the reset setting of 16
    add_row(pt_row(1'b0, 16'sh1234, -16'sh0800, 16'sh0100,
                   16'sh0400, 16'sh0000, -16'sh0400));
    // count of zero behaves as one
    add_row(cfg_row(7'd0));
    add_row(typed_row(pt_row(1'b0, SAT_HI, SAT_HI, SAT_HI,
                             SAT_HI, SAT_HI, SAT_HI),
                      16'sh1234, -16'sh0800, 16'sh0100));
    // new curve mid-stream: stored only, then the minimum comes back out
    add_row(pt_row(1'b1, SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO));
    add_row(typed_row(pt_row(1'b0, 0, 0, 0, SAT_HI, SAT_HI, SAT_HI),
                      SAT_LO, SAT_LO, SAT_LO));
    add_row(cfg_row(7'd1));
    add_row(typed_row(pt_row(1'b0, 1, -1, 0, 0, 0, 0), 0, 0, 0));
    // counts above the maximum clamp to 64; tangents drive both rails
    add_row(cfg_row(7'd127));
    add_row(pt_row(1'b1, SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI));
    add_row(pt_row(1'b0, SAT_HI, SAT_HI, SAT_HI, SAT_LO, SAT_LO, SAT_LO));
    add_row(pt_row(1'b1, SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO));
    add_row(pt_row(1'b0, SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI));
    add_row(cfg_row(7'd64));
    add_row(pt_row(1'b0, 0, 0, 0, 0, 0, 0));
    add_row(cfg_row(7'd2));
    add_row(pt_row(1'b0, -1, 1, 16'sh00ff, 16'sh0100, -16'sh0100, 1));
    add_row(pt_row(1'b0, 16'sh5555, -16'sh5556, 16'sh2aaa,
                   -16'sh2aab, 16'sh7f00, -16'sh7f00));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[k]) begin
      if (stim_rows[k].kind == ROW_CFG) write_samples_setting(stim_rows[k].setting);
      else send_point(stim_rows[k]);
    end

    // Random curves: short curves of random content under a spread of
    // settings; big counts get few points to keep the run short.
    phase_settings = '{7'd3, 7'd0, 7'd7, 7'd127, 7'd2, 7'd64, 7'd5, 7'd1, 7'd11,
                       chcs_pkg::NW'($urandom_range(1, 12))};
    foreach (phase_settings[ph]) begin
      write_samples_setting(phase_settings[ph]);
      calm        = (ph % 4 == 2);
      n_eff       = (phase_settings[ph] == 0) ? 1 : phase_settings[ph];
      phase_items = (n_eff >= 32) ? 8 : 25;
      for (int unsigned k = 0; k < phase_items; k++) begin
        row = pt_row($urandom_range(0, 7) == 0, pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(), pick_coord());
        // sometimes hold back until the pipeline is empty
        if ($urandom_range(0, 24) == 0) settle();
        send_point(row);
      end
    end
    calm = 1'b0;

    settle();

    $display("%0d control points over %0d sample-count settings (0 and 127 included)",
             points_sent, settings_used);
    $display("%0d samples compared, %0d segments closed, %0d samples at a rail",
             samples_checked, segments_closed, rail_hits);
    if (mismatches == 0) begin
      $display("tb_cubic_hermite_curve_sampler: done, clean");
    end else begin
      $display("tb_cubic_hermite_curve_sampler: done, errors");
    end
    $finish;
  end

endmodule
